// ===== hdl/rpt_pkg.sv =====
`timescale 1ns / 1ps
package rpt_pkg;

    localparam int CORDIC_STEPS   = 16;
    localparam int COEF_FRAC_BITS = 14;
    localparam int QI_FRAC        = 30;
    localparam int ATAN_COUNT     = 24;
    localparam int CW             = 34;
    localparam int ZW             = 34;
    localparam int NSTEP          = (CORDIC_STEPS < ATAN_COUNT) ? CORDIC_STEPS : ATAN_COUNT;
    localparam int ESHIFT         = QI_FRAC - COEF_FRAC_BITS;
    localparam int LIM_RAW        = 1 << COEF_FRAC_BITS;
    localparam int LIM            = (LIM_RAW > 32767) ? 32767 : LIM_RAW;

    localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh26DD3B6A;

    typedef logic signed [CW-1:0] t_q;

    // atan(2^-i) in Q2.30, truncated
    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        logic [31:0] v;
        unique case (i)
            0: v = 32'h3243F6A8;   1: v = 32'h1DAC6705;
            2: v = 32'h0FADBAFC;   3: v = 32'h07F56EA6;
            4: v = 32'h03FEAB76;   5: v = 32'h01FFD55B;
            6: v = 32'h00FFFAAA;   7: v = 32'h007FFF55;
            8: v = 32'h003FFFEA;   9: v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;  11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;  13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;  15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;  17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;  19: v = 32'h000007FF;
            20: v = 32'h000003FF;  21: v = 32'h000001FF;
            22: v = 32'h000000FF;  23: v = 32'h0000007F;
            default: v = 32'h0;
        endcase
        return ZW'($signed({1'b0, v}));
    endfunction

    // q4.30 product, rounded half up
    function automatic t_q qmul(input t_q a, input t_q b);
        logic signed [2*CW-1:0] p;
        p = a * b + (68'sd1 <<< (QI_FRAC - 1));
        return CW'(p >>> QI_FRAC);
    endfunction

    // round to entry width and clamp
    function automatic logic signed [15:0] to_entry(input logic signed [CW:0] v);
        logic signed [CW:0] r;
        r = (v + ((CW+1)'(1) <<< (ESHIFT - 1))) >>> ESHIFT;
        if (r > (CW+1)'(LIM)) r = (CW+1)'(LIM);
        if (r < -(CW+1)'(LIM)) r = -(CW+1)'(LIM);
        return r[15:0];
    endfunction

endpackage

// ===== hdl/rpy_pose_to_transform_core.sv =====
`timescale 1ns / 1ps
// channel | valid   | stall   | payload
// in      | i_valid | o_stall | i_pos_x/y/z, i_roll/pitch/yaw_angle
// out     | o_valid | i_stall | o_m00..o_m22, o_tx/ty/tz
// one pose per cycle while the output is not stalled
// the cordic stage chain sets the depth; two product stages and a rounding stage follow
// synchronous active-low reset clears the valid bits only
// a stall at the output freezes the whole pipeline; no beat is lost
module rpy_pose_to_transform_core import rpt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [15:0] i_roll_angle,
    input  logic signed [15:0] i_pitch_angle,
    input  logic signed [15:0] i_yaw_angle,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_m00,
    output logic signed [15:0] o_m01,
    output logic signed [15:0] o_m02,
    output logic signed [15:0] o_m10,
    output logic signed [15:0] o_m11,
    output logic signed [15:0] o_m12,
    output logic signed [15:0] o_m20,
    output logic signed [15:0] o_m21,
    output logic signed [15:0] o_m22,
    output logic signed [31:0] o_tx,
    output logic signed [31:0] o_ty,
    output logic signed [31:0] o_tz
);
    localparam int LAT = NSTEP + 1;   // cordic register depth

    // pipeline advances unless the output beat is held
    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    t_q sr, cr, sp, cp, sy, cy;
    rpt_cordic u_roll  (.i_clk, .i_en(en), .i_angle(i_roll_angle),  .o_sin(sr), .o_cos(cr));
    rpt_cordic u_pitch (.i_clk, .i_en(en), .i_angle(i_pitch_angle), .o_sin(sp), .o_cos(cp));
    rpt_cordic u_yaw   (.i_clk, .i_en(en), .i_angle(i_yaw_angle),   .o_sin(sy), .o_cos(cy));

    // valid bits and translation travel alongside the cordic, product and rounding stages
    logic              r_v  [LAT+3];
    logic signed [31:0] r_px [LAT+3];
    logic signed [31:0] r_py [LAT+3];
    logic signed [31:0] r_pz [LAT+3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT + 3; k++) r_v[k] <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < LAT + 3; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px[0] <= i_pos_x; r_py[0] <= i_pos_y; r_pz[0] <= i_pos_z;
            for (int k = 1; k < LAT + 3; k++) begin
                r_px[k] <= r_px[k-1]; r_py[k] <= r_py[k-1]; r_pz[k] <= r_pz[k-1];
            end
        end
    end

    // stage a: pair products
    t_q r_cysp, r_sysp, r_cycp, r_sycp, r_sycr, r_sysr, r_cycr, r_cysr;
    t_q r_cpsr, r_cpcr, r_sra, r_cra, r_nsp;
    // stage b: triple products
    t_q r_t01, r_t02, r_t11, r_t12, r_b01, r_b02, r_b11, r_b12;
    t_q r_m00, r_m10, r_m20, r_m21, r_m22;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cysp <= qmul(cy, sp);  r_sysp <= qmul(sy, sp);
            r_cycp <= qmul(cy, cp);  r_sycp <= qmul(sy, cp);
            r_sycr <= qmul(sy, cr);  r_sysr <= qmul(sy, sr);
            r_cycr <= qmul(cy, cr);  r_cysr <= qmul(cy, sr);
            r_cpsr <= qmul(cp, sr);  r_cpcr <= qmul(cp, cr);
            r_sra  <= sr;            r_cra  <= cr;
            r_nsp  <= -sp;

            r_t01 <= qmul(r_cysp, r_sra); r_t02 <= qmul(r_cysp, r_cra);
            r_t11 <= qmul(r_sysp, r_sra); r_t12 <= qmul(r_sysp, r_cra);
            r_b01 <= r_sycr; r_b02 <= r_sysr; r_b11 <= r_cycr; r_b12 <= r_cysr;
            r_m00 <= r_cycp; r_m10 <= r_sycp; r_m20 <= r_nsp;
            r_m21 <= r_cpsr; r_m22 <= r_cpcr;

            // stage c: sums, rounding, output register
            o_m00 <= to_entry((CW+1)'(r_m00));
            o_m01 <= to_entry((CW+1)'(r_t01) - (CW+1)'(r_b01));
            o_m02 <= to_entry((CW+1)'(r_t02) + (CW+1)'(r_b02));
            o_m10 <= to_entry((CW+1)'(r_m10));
            o_m11 <= to_entry((CW+1)'(r_t11) + (CW+1)'(r_b11));
            o_m12 <= to_entry((CW+1)'(r_t12) - (CW+1)'(r_b12));
            o_m20 <= to_entry((CW+1)'(r_m20));
            o_m21 <= to_entry((CW+1)'(r_m21));
            o_m22 <= to_entry((CW+1)'(r_m22));
        end
    end

    assign o_valid = r_v[LAT+2];
    assign o_tx    = r_px[LAT+2];
    assign o_ty    = r_py[LAT+2];
    assign o_tz    = r_pz[LAT+2];
endmodule

// ===== hdl/rpt_cordic.sv =====
`timescale 1ns / 1ps
module rpt_cordic import rpt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [15:0]  i_angle,
    output t_q                  o_sin,
    output t_q                  o_cos
);
    // one iteration per stage, advancing on i_en
    logic signed [ZW-1:0] z0;
    logic                 f0;
    t_q                   r_x [NSTEP+1];
    t_q                   r_y [NSTEP+1];
    logic signed [ZW-1:0] r_z [NSTEP+1];
    logic                 r_f [NSTEP+1];

    always_comb begin
        z0 = ZW'(i_angle) <<< 17;
        f0 = 1'b0;
        if (z0 > HALF_PI_Q30) begin
            z0 = z0 - PI_Q30; f0 = 1'b1;
        end else if (z0 < -HALF_PI_Q30) begin
            z0 = z0 + PI_Q30; f0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= CORDIC_GAIN;
            r_y[0] <= '0;
            r_z[0] <= z0;
            r_f[0] <= f0;
        end
    end

    for (genvar i = 0; i < NSTEP; i++) begin : g_it
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_f[i+1] <= r_f[i];
                if (!r_z[i][ZW-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - atan_q30(i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + atan_q30(i);
                end
            end
        end
    end

    assign o_cos = r_f[NSTEP] ? -r_x[NSTEP] : r_x[NSTEP];
    assign o_sin = r_f[NSTEP] ? -r_y[NSTEP] : r_y[NSTEP];
endmodule

// ===== hdl/rpt_checker.sv =====
`timescale 1ns / 1ps
module rpt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [15:0] o_m20,
    input logic signed [15:0] o_m00,
    input logic signed [31:0] o_tx
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_tx) && $stable(o_m00))
        else $error("held beat changed");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without cause");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_m20 <= 16'sd16384 && o_m20 >= -16'sd16384
                 && o_m00 <= 16'sd16384 && o_m00 >= -16'sd16384)
        else $error("entry out of range");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule

bind rpy_pose_to_transform_core rpt_checker u_chk (.*);

// ===== tb/sv/rpy_pose_to_transform_core_tb.sv =====
`timescale 1ns / 1ps
module rpy_pose_to_transform_core_tb;
    import rpt_pkg::*;

    // one pose in, one transform out
    typedef struct {
        logic signed [31:0] px, py, pz;
        logic signed [15:0] roll, pitch, yaw;
    } t_pose;

    typedef struct {
        logic signed [15:0] m [9];
        logic signed [31:0] t [3];
    } t_xform;

    typedef struct {
        t_pose pose;
        bit    known;   // expected rotation typed into the row
        logic signed [15:0] m [9];
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_pos_x, i_pos_y, i_pos_z;
    logic signed [15:0] i_roll_angle, i_pitch_angle, i_yaw_angle;
    logic               o_valid;
    logic               i_stall;
    logic signed [15:0] o_m00, o_m01, o_m02, o_m10, o_m11, o_m12, o_m20, o_m21, o_m22;
    logic signed [31:0] o_tx, o_ty, o_tz;

    rpy_pose_to_transform_core dut (.*);

    t_xform pending_xforms [$];
    int     errors    = 0;
    int     idle_cyc  = 0;
    bit     hold_out  = 0;   // long receiver hold-off request
    bit     calm      = 0;   // stretch with no idling

    initial begin
        i_clk = 0;
    end
    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // ---------------- predictor ----------------
    localparam logic signed [63:0] PI64   = 64'sd3373259426;
    localparam logic signed [63:0] HPI64  = 64'sd1686629713;
    localparam logic signed [63:0] GAIN64 = 64'sh26DD3B6A;

    // arctangent table, Q2.30 truncated
    localparam logic [31:0] ARCTAN [24] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
        32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F};

    function automatic void angle_sincos(input logic signed [15:0] a,
                                         output logic signed [63:0] s,
                                         output logic signed [63:0] c);
        logic signed [63:0] z, x, y, nx;
        bit flip;
        z = 64'(a) * 64'sd131072;
        x = GAIN64;
        y = 0;
        flip = 0;
        // fold into plus or minus half pi, flip signs afterwards
        if (z > HPI64) begin
            z = z - PI64;
            flip = 1;
        end else if (z < -HPI64) begin
            z = z + PI64;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - 64'(ARCTAN[i]);
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + 64'(ARCTAN[i]);
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic logic signed [63:0] q30_mul(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] p;
        p = a * b + (64'sd1 <<< 29);
        return p >>> 30;
    endfunction

    function automatic logic signed [15:0] coef_round(input logic signed [63:0] v);
        logic signed [63:0] r, lim;
        lim = 64'sd1 <<< COEF_FRAC_BITS;
        if (lim > 32767) lim = 32767;
        r = (v + (64'sd1 <<< (30 - COEF_FRAC_BITS - 1))) >>> (30 - COEF_FRAC_BITS);
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r[15:0];
    endfunction

    function automatic t_xform pose_transform(input t_pose p);
        t_xform o;
        logic signed [63:0] sr, cr, sp, cp, sy, cy, cysp, sysp;
        angle_sincos(p.roll, sr, cr);
        angle_sincos(p.pitch, sp, cp);
        angle_sincos(p.yaw, sy, cy);
        cysp = q30_mul(cy, sp);
        sysp = q30_mul(sy, sp);
        o.m[0] = coef_round(q30_mul(cy, cp));
        o.m[1] = coef_round(q30_mul(cysp, sr) - q30_mul(sy, cr));
        o.m[2] = coef_round(q30_mul(cysp, cr) + q30_mul(sy, sr));
        o.m[3] = coef_round(q30_mul(sy, cp));
        o.m[4] = coef_round(q30_mul(sysp, sr) + q30_mul(cy, cr));
        o.m[5] = coef_round(q30_mul(sysp, cr) - q30_mul(cy, sr));
        o.m[6] = coef_round(-sp);
        o.m[7] = coef_round(q30_mul(cp, sr));
        o.m[8] = coef_round(q30_mul(cp, cr));
        o.t[0] = p.px;
        o.t[1] = p.py;
        o.t[2] = p.pz;
        return o;
    endfunction

    // ---------------- stimulus ----------------
    function automatic logic signed [15:0] rand_angle(input int mode);
        case (mode)
            0: return 16'($urandom_range(0, 2 * 25736) - 25736);
            1: return 16'($urandom);                 // any pattern, wraps past pi
            default: return 16'($urandom_range(0, 2 * 804) - 804);  // near zero
        endcase
    endfunction

    function automatic t_pose rand_pose();
        t_pose p;
        int mode;
        mode = $urandom_range(0, 9);
        mode = (mode < 7) ? 0 : (mode < 9 ? 1 : 2);
        p.px = $urandom;
        p.py = $urandom;
        p.pz = $urandom;
        p.roll  = rand_angle(mode);
        p.pitch = rand_angle(mode);
        p.yaw   = rand_angle(mode);
        return p;
    endfunction

    // drive one beat, hold it until the block takes it; valid stays high after
    task automatic send_pose(input t_pose p, input t_xform exp_x);
        if (!calm) begin
            while ($urandom_range(0, 99) < 16) begin
                i_valid <= 0;
                @(negedge i_clk);
            end
        end
        i_valid       <= 1;
        i_pos_x       <= p.px;
        i_pos_y       <= p.py;
        i_pos_z       <= p.pz;
        i_roll_angle  <= p.roll;
        i_pitch_angle <= p.pitch;
        i_yaw_angle   <= p.yaw;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_xforms.push_back(exp_x);
        @(negedge i_clk);
    endtask

    function automatic t_row mk_row(input logic signed [15:0] r, input logic signed [15:0] pt,
                                    input logic signed [15:0] y, input bit known,
                                    input logic signed [15:0] mv [9]);
        t_row w;
        w.pose.px = $urandom;
        w.pose.py = $urandom;
        w.pose.pz = $urandom;
        w.pose.roll = r;
        w.pose.pitch = pt;
        w.pose.yaw = y;
        w.known = known;
        w.m = mv;
        return w;
    endfunction

    localparam logic signed [15:0] PI_A  = 16'sd25736;
    localparam logic signed [15:0] HPI_A = 16'sd12868;
    localparam logic signed [15:0] ONE   = 16'sd16384;

    t_row dir_rows [$];

    task automatic build_rows();
        logic signed [15:0] ident [9];
        logic signed [15:0] none [9];
        t_row w;
        ident = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
        none  = '{default: 0};
        // zero angles give the identity
        w = mk_row(0, 0, 0, 1, ident);
        dir_rows.push_back(w);
        // translation extremes
        w = mk_row(0, 0, 0, 1, ident);
        w.pose.px = 32'sh7FFFFFFF; w.pose.py = 32'sh80000000; w.pose.pz = 0;
        dir_rows.push_back(w);
        w = mk_row(0, 0, 0, 1, ident);
        w.pose.px = 32'sh80000000; w.pose.py = -1; w.pose.pz = 32'sh7FFFFFFF;
        dir_rows.push_back(w);
        // angle extremes, folding boundaries, wrapped patterns
        dir_rows.push_back(mk_row(PI_A, 0, 0, 0, none));
        dir_rows.push_back(mk_row(-PI_A, 0, 0, 0, none));
        dir_rows.push_back(mk_row(0, PI_A, 0, 0, none));
        dir_rows.push_back(mk_row(0, -PI_A, 0, 0, none));
        dir_rows.push_back(mk_row(0, 0, PI_A, 0, none));
        dir_rows.push_back(mk_row(0, 0, -PI_A, 0, none));
        dir_rows.push_back(mk_row(HPI_A, HPI_A, HPI_A, 0, none));
        dir_rows.push_back(mk_row(-HPI_A, -HPI_A, -HPI_A, 0, none));
        dir_rows.push_back(mk_row(HPI_A + 1, HPI_A - 1, -HPI_A - 1, 0, none));
        dir_rows.push_back(mk_row(16'sh7FFF, 16'sh8000, 16'sh7FFF, 0, none));
        dir_rows.push_back(mk_row(16'sh8000, 16'sh7FFF, 16'sh8000, 0, none));
        dir_rows.push_back(mk_row(-1, 1, -1, 0, none));
        dir_rows.push_back(mk_row(16'sh5555, 16'shAAAA, 16'sh1234, 0, none));
        dir_rows.push_back(mk_row(PI_A, PI_A, PI_A, 0, none));
    endtask

    // ---------------- receiver ----------------
    always @(negedge i_clk) begin
        if (!i_rst_n)
            i_stall <= 0;
        else if (hold_out)
            i_stall <= 1;
        else if (calm)
            i_stall <= 0;
        else
            i_stall <= ($urandom_range(0, 99) < 16);
    end

    always @(posedge i_clk) begin
        t_xform e;
        logic signed [15:0] got_m [9];
        logic signed [31:0] got_t [3];
        if (i_rst_n && o_valid && !i_stall) begin
            got_m = '{o_m00, o_m01, o_m02, o_m10, o_m11, o_m12, o_m20, o_m21, o_m22};
            got_t = '{o_tx, o_ty, o_tz};
            if (pending_xforms.size() == 0) begin
                $display("%0t: transform beat with none expected", $time);
                errors++;
            end else begin
                e = pending_xforms.pop_front();
                for (int k = 0; k < 9; k++)
                    if (got_m[k] !== e.m[k]) begin
                        $display("%0t: m%0d%0d expected %0d actual %0d",
                                 $time, k / 3, k % 3, e.m[k], got_m[k]);
                        errors++;
                    end
                for (int k = 0; k < 3; k++)
                    if (got_t[k] !== e.t[k]) begin
                        $display("%0t: t%0d expected %h actual %h",
                                 $time, k, e.t[k], got_t[k]);
                        errors++;
                    end
            end
        end
    end

    // watchdog: cycles with no beat on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
        if (idle_cyc > 5000) begin
            $display("rpy_pose_to_transform_core_tb: FAIL");
            $finish;
        end
    end

    // long output hold-off while the sender keeps pushing
    initial begin
        wait (i_rst_n);
        repeat (500) @(negedge i_clk);
        hold_out = 1;
        repeat (200) @(negedge i_clk);
        hold_out = 0;
    end

    initial begin
        t_xform exp_x;
        i_rst_n = 0;
        i_valid = 0;
        i_pos_x = 0; i_pos_y = 0; i_pos_z = 0;
        i_roll_angle = 0; i_pitch_angle = 0; i_yaw_angle = 0;
        build_rows();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed table
        foreach (dir_rows[n]) begin
            exp_x = pose_transform(dir_rows[n].pose);
            if (dir_rows[n].known) exp_x.m = dir_rows[n].m;
            send_pose(dir_rows[n].pose, exp_x);
        end

        // random poses, a quiet stretch and a drain pause partway through
        for (int n = 0; n < 1550; n++) begin
            t_pose p;
            if (n == 300) calm = 1;
            if (n == 600) calm = 0;
            if (n == 900) begin
                i_valid <= 0;
                wait (pending_xforms.size() == 0);
                @(negedge i_clk);
            end
            p = rand_pose();
            send_pose(p, pose_transform(p));
        end
        i_valid <= 0;

        wait (pending_xforms.size() == 0);
        repeat (CORDIC_STEPS + 30) @(posedge i_clk);
        if (errors == 0)
            $display("rpy_pose_to_transform_core_tb: PASS");
        else
            $display("rpy_pose_to_transform_core_tb: FAIL");
        $finish;
    end

endmodule
